// File: sv/nms_pkg.sv
// Shared types, constants and the sigmoid table builder of the neuron MAC block.
package nms_pkg;

   // Field widths fixed by the item format
   localparam int ADDR_W = 10;
   localparam int DATA_W = 16;
   localparam int ACT_W  = 16;
   localparam int ACC_W  = 44;

   // Parameter defaults
   localparam int WEIGHT_DEPTH_DEF   = 1024;
   localparam int FRAC_BITS_DEF      = 12;
   localparam int SIG_TABLE_BITS_DEF = 8;

   // Largest supported sigmoid table
   localparam int SIG_MAX_BITS    = 12;
   localparam int SIG_MAX_ENTRIES = 1 << SIG_MAX_BITS;

   // Item kinds
   localparam logic FUNC_WEIGHT  = 1'b0;
   localparam logic FUNC_ELEMENT = 1'b1;

   // Saturated output codes
   localparam logic [ACT_W-1:0] ACT_LOW  = '0;
   localparam logic [ACT_W-1:0] ACT_HIGH = '1;

   // Accumulator limits
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef logic [SIG_MAX_ENTRIES-1:0][ACT_W-1:0] sig_tbl_type;

   typedef struct packed {
      logic                     func;
      logic [ADDR_W-1:0]        weight_addr;
      logic signed [DATA_W-1:0] weight_value;
      logic signed [DATA_W-1:0] x_value;
      logic [ADDR_W-1:0]        start_index;
      logic signed [DATA_W-1:0] bias;
      logic                     last;
   } req_item_type;

   // Element leaving the weight read stage
   typedef struct packed {
      logic                     valid;
      logic                     first;
      logic                     last;
      logic signed [DATA_W-1:0] bias;
      logic signed [DATA_W-1:0] x;
   } elem_type;

   // Finished sum waiting for the activation stage
   typedef struct packed {
      logic                    valid;
      logic signed [ACC_W-1:0] sum;
   } fin_type;

   // Unsigned restoring division, used only while building constants
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Q0.32 product, rounded half up
   function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] p;
      p = a * b + 64'h8000_0000;
      return p >> 32;
   endfunction

   // Sigmoid of each bin midpoint over [-8,8), Q0.16, saturated
   function automatic sig_tbl_type sig_table_fn(input int tb);
      sig_tbl_type        t;
      logic [63:0]        u;
      logic [63:0]        term;
      logic [63:0]        e1;
      logic [63:0]        e2;
      logic [63:0]        cur;
      logic [63:0]        d;
      logic [63:0]        pos;
      logic [63:0]        neg;
      logic signed [63:0] ser;
      int                 half;
      t    = '0;
      u    = 64'd1 << (35 - tb);
      term = 64'd1 << 32;
      ser  = 64'sd1 <<< 32;
      half = 1 << (tb - 1);
      // e^-u by Taylor series
      for (int j = 1; j <= 12; j++) begin
         term = udiv64((term * u) >> 32, 64'(j));
         if ((j & 1) != 0) ser = ser - signed'(term);
         else ser = ser + signed'(term);
      end
      e1  = unsigned'(ser);
      e2  = mul_q32(e1, e1);
      cur = e1;
      for (int j = 0; j < half; j++) begin
         d   = (64'd1 << 32) + cur;
         pos = udiv64((64'd1 << 48) + (d >> 1), d);
         neg = udiv64((cur << 16) + (d >> 1), d);
         t[half + j]     = (pos > 64'd65535) ? ACT_HIGH : pos[ACT_W-1:0];
         t[half - 1 - j] = (neg > 64'd65535) ? ACT_HIGH : neg[ACT_W-1:0];
         cur = mul_q32(cur, e2);
      end
      return t;
   endfunction

endpackage

// File: sv/nms_req_if.sv
// Request channel: weight writes and input elements.
interface nms_req_if;
   import nms_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     func;
   logic [ADDR_W-1:0]        weight_addr;
   logic signed [DATA_W-1:0] weight_value;
   logic signed [DATA_W-1:0] x_value;
   logic [ADDR_W-1:0]        start_index;
   logic signed [DATA_W-1:0] bias;
   logic                     last;

   modport source (
      output valid, func, weight_addr, weight_value, x_value, start_index, bias, last,
      input  ready
   );
   modport sink (
      input  valid, func, weight_addr, weight_value, x_value, start_index, bias, last,
      output ready
   );
endinterface

// File: sv/nms_rsp_if.sv
// Response channel: one activation per neuron.
interface nms_rsp_if;
   import nms_pkg::*;

   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] activation;
   logic             clamped;

   modport source (
      output valid, activation, clamped,
      input  ready
   );
   modport sink (
      input  valid, activation, clamped,
      output ready
   );
endinterface

// File: sv/nms_wmem.sv
// Weight memory with element address generation and the registered read stage.
module nms_wmem #(
   parameter int WEIGHT_DEPTH = nms_pkg::WEIGHT_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  nms_pkg::req_item_type                 item,
   input  logic                                  s1_free,
   output nms_pkg::elem_type                     s1,
   output logic signed [nms_pkg::DATA_W-1:0]     weight,
   output logic                                  fresh
);
   import nms_pkg::*;

   localparam int AW = $clog2(WEIGHT_DEPTH);

   logic signed [DATA_W-1:0] weight_mem [WEIGHT_DEPTH];

   logic signed [DATA_W-1:0] weight_ff;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_first_ff, s1_last_ff;
   logic signed [DATA_W-1:0] s1_bias_ff, s1_x_ff;
   logic [AW-1:0]            base_ff, base_in;
   logic [AW-1:0]            idx_ff, idx_in;
   logic                     fresh_ff, fresh_in;

   logic          elem_acc, wr_acc;
   logic [AW-1:0] wr_addr, start_addr, rd_addr;
   logic [AW:0]   sum_addr;

   // Reduce a request address into the store range
   function automatic logic [AW-1:0] addr_wrap(input logic [ADDR_W-1:0] a);
      int r;
      r = int'(a);
      for (int k = 5; k >= 0; k--) begin
         if (r >= (WEIGHT_DEPTH << k)) r = r - (WEIGHT_DEPTH << k);
      end
      return AW'(r);
   endfunction

   assign elem_acc   = accept && (item.func == FUNC_ELEMENT);
   assign wr_acc     = accept && (item.func == FUNC_WEIGHT);
   assign wr_addr    = addr_wrap(item.weight_addr);
   assign start_addr = addr_wrap(item.start_index);

   // Weight address of this element: start index on a neuron's first element, else base plus index, wrapped
   always_comb begin
      sum_addr = {1'b0, base_ff} + {1'b0, idx_ff};
      if (sum_addr >= (AW+1)'(WEIGHT_DEPTH)) sum_addr = sum_addr - (AW+1)'(WEIGHT_DEPTH);
      rd_addr = fresh_ff ? start_addr : sum_addr[AW-1:0];
   end

   // Advance the neuron position on each element
   always_comb begin
      base_in  = base_ff;
      idx_in   = idx_ff;
      fresh_in = fresh_ff;
      if (elem_acc) begin
         if (fresh_ff) begin
            base_in = start_addr;
            idx_in  = AW'(1);
         end else if (idx_ff == AW'(WEIGHT_DEPTH - 1)) begin
            idx_in = '0;
         end else begin
            idx_in = idx_ff + AW'(1);
         end
         fresh_in = item.last;
      end
   end

   assign s1_valid_in = s1_free ? elem_acc : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= '0;
         idx_ff      <= '0;
         fresh_ff    <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         base_ff     <= base_in;
         idx_ff      <= idx_in;
         fresh_ff    <= fresh_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Store weights and read the element's weight
   always_ff @(posedge clock) begin
      if (wr_acc) weight_mem[wr_addr] <= item.weight_value;
      if (elem_acc) weight_ff <= weight_mem[rd_addr];
   end

   // Hold the element beside its weight
   always_ff @(posedge clock) begin
      if (elem_acc) begin
         s1_first_ff <= fresh_ff;
         s1_last_ff  <= item.last;
         s1_bias_ff  <= item.bias;
         s1_x_ff     <= item.x_value;
      end
   end

   assign s1.valid = s1_valid_ff;
   assign s1.first = s1_first_ff;
   assign s1.last  = s1_last_ff;
   assign s1.bias  = s1_bias_ff;
   assign s1.x     = s1_x_ff;
   assign weight   = weight_ff;
   assign fresh    = fresh_ff;

endmodule

// File: sv/nms_mac.sv
// Multiply stage and saturating accumulator with the finished-sum holding register.
module nms_mac #(
   parameter int FRAC_BITS = nms_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  nms_pkg::elem_type                 s1,
   input  logic signed [nms_pkg::DATA_W-1:0] weight,
   output logic                              s1_free,
   input  logic                              out_free,
   output nms_pkg::fin_type                  fin
);
   import nms_pkg::*;

   localparam int PROD_W = 2 * DATA_W;

   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_first_ff, s2_last_ff;
   logic signed [DATA_W-1:0] s2_bias_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  sum_ff;
   logic                     fin_valid_ff, fin_valid_in;

   logic                    fin_free, s2_go, s2_free;
   logic signed [ACC_W-1:0] acc_base, acc_sat;
   logic signed [ACC_W:0]   acc_wide;

   // Stall chain: only a last element needs room downstream
   assign fin_free = !fin_valid_ff || out_free;
   assign s2_go    = s2_valid_ff && (!s2_last_ff || fin_free);
   assign s2_free  = !s2_valid_ff || s2_go;
   assign s1_free  = !s1.valid || s2_free;

   // Seed with the bias on the first element, then add and saturate
   always_comb begin
      acc_base = s2_first_ff ? (ACC_W'(s2_bias_ff) <<< FRAC_BITS) : acc_ff;
      acc_wide = (ACC_W+1)'(acc_base) + (ACC_W+1)'(prod_ff);
      if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
         acc_sat = acc_wide[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_sat = acc_wide[ACC_W-1:0];
      end
   end

   assign s2_valid_in  = s2_free ? s1.valid : s2_valid_ff;
   assign fin_valid_in = fin_free ? (s2_go && s2_last_ff) : fin_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   // Register the product
   always_ff @(posedge clock) begin
      if (s1.valid && s2_free) begin
         prod_ff     <= PROD_W'(weight) * PROD_W'(s1.x);
         s2_first_ff <= s1.first;
         s2_last_ff  <= s1.last;
         s2_bias_ff  <= s1.bias;
      end
   end

   // Accumulate, and capture the neuron's sum on its last element
   always_ff @(posedge clock) begin
      if (s2_go) acc_ff <= acc_sat;
      if (s2_go && s2_last_ff) sum_ff <= acc_sat;
   end

   assign fin.valid = fin_valid_ff;
   assign fin.sum   = sum_ff;

endmodule

// File: sv/nms_act.sv
// Sigmoid table lookup with range clamping and the output register.
module nms_act #(
   parameter int FRAC_BITS          = nms_pkg::FRAC_BITS_DEF,
   parameter int SIGMOID_TABLE_BITS = nms_pkg::SIG_TABLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  nms_pkg::fin_type                 fin,
   output logic                             out_free,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [nms_pkg::ACT_W-1:0]        rsp_activation,
   output logic                             rsp_clamped
);
   import nms_pkg::*;

   localparam int TB       = SIGMOID_TABLE_BITS;
   localparam int IdxShift = 2 * FRAC_BITS + 4 - TB;
   localparam logic signed [ACC_W:0] OffBias  = (ACC_W+1)'(64'sd1 <<< (2 * FRAC_BITS + 3));
   localparam logic signed [ACC_W:0] RangeTop = (ACC_W+1)'(64'sd1 <<< (2 * FRAC_BITS + 4));
   localparam sig_tbl_type SigTable = sig_table_fn(SIGMOID_TABLE_BITS);

   logic             rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0] act_ff, act_in;
   logic             clamped_ff, clamped_in;

   logic signed [ACC_W:0] off;
   logic [TB-1:0]         idx;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Shift the sum to [0,16) and pick the bin, clamp outside
   always_comb begin
      off = (ACC_W+1)'(fin.sum) + OffBias;
      idx = TB'(off[ACC_W-1:0] >> IdxShift);
      if (off < 0) begin
         act_in     = ACT_LOW;
         clamped_in = 1'b1;
      end else if (off >= RangeTop) begin
         act_in     = ACT_HIGH;
         clamped_in = 1'b1;
      end else begin
         act_in     = SigTable[SIG_MAX_BITS'(idx)];
         clamped_in = 1'b0;
      end
   end

   assign rsp_valid_in = out_free ? fin.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   // Load the result when the output slot is free
   always_ff @(posedge clock) begin
      if (fin.valid && out_free) begin
         act_ff     <= act_in;
         clamped_ff <= clamped_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_activation = act_ff;
   assign rsp_clamped    = clamped_ff;

endmodule

// File: sv/neuron_mac_sigmoid.sv
// Usage: one neuron with weight store, multiply-accumulate and sigmoid output.
// The req channel carries two kinds of transfer. func = weight writes
// weight_value into the weight memory at weight_addr. func = element feeds
// x_value; the first element of a neuron also takes start_index and bias.
// Each element is multiplied by the weight at start_index plus its position,
// wrapped to the memory depth, and added to a saturating 44-bit sum.
// The element flagged last makes one rsp transfer: activation in Q0.16 and
// clamped, set when the sum lay outside [-8,8).
// Throughput: one req transfer per cycle, of either kind, while req ready is
// high; the single weight memory port serves one write or one read per cycle.
// A last element's result passes the weight read, multiply and accumulate
// registers, then the table lookup into the output register that drives rsp valid.
// Reset clears the neuron position and the pipeline; the weight memory keeps
// its contents and must be written before it is read.
// When the receiver stalls, the output register and one finished-sum register
// hold results; ordinary elements keep flowing, and req ready falls only once
// a last element reaches a full holding register.
module neuron_mac_sigmoid #(
   parameter int WEIGHT_DEPTH       = nms_pkg::WEIGHT_DEPTH_DEF,
   parameter int FRAC_BITS          = nms_pkg::FRAC_BITS_DEF,
   parameter int SIGMOID_TABLE_BITS = nms_pkg::SIG_TABLE_BITS_DEF
) (
   input logic    clock,
   input logic    reset,
   nms_req_if.sink   req,
   nms_rsp_if.source rsp
);
   import nms_pkg::*;

   req_item_type             item;
   elem_type                 s1;
   fin_type                  fin;
   logic signed [DATA_W-1:0] weight;
   logic                     s1_free, out_free, fresh, accept;

   assign item.func         = req.func;
   assign item.weight_addr  = req.weight_addr;
   assign item.weight_value = req.weight_value;
   assign item.x_value      = req.x_value;
   assign item.start_index  = req.start_index;
   assign item.bias         = req.bias;
   assign item.last         = req.last;

   assign req.ready = s1_free;
   assign accept    = req.valid && req.ready;

   nms_wmem #(.WEIGHT_DEPTH(WEIGHT_DEPTH)) u_wmem (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .item    (item),
      .s1_free (s1_free),
      .s1      (s1),
      .weight  (weight),
      .fresh   (fresh)
   );

   nms_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock    (clock),
      .reset    (reset),
      .s1       (s1),
      .weight   (weight),
      .s1_free  (s1_free),
      .out_free (out_free),
      .fin      (fin)
   );

   nms_act #(
      .FRAC_BITS          (FRAC_BITS),
      .SIGMOID_TABLE_BITS (SIGMOID_TABLE_BITS)
   ) u_act (
      .clock          (clock),
      .reset          (reset),
      .fin            (fin),
      .out_free       (out_free),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_activation (rsp.activation),
      .rsp_clamped    (rsp.clamped)
   );

   // A last element re-arms the neuron
   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      (accept && req.func == FUNC_ELEMENT && req.last) |=> fresh)
      else $error("neuron not re-armed after last element");

   // Every element transfer enters the weight read stage
   a_elem_staged: assert property (@(posedge clock) disable iff (reset)
      (accept && req.func == FUNC_ELEMENT) |=> s1.valid)
      else $error("element lost at weight read stage");

   // A new result comes only from a held finished sum
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(fin.valid))
      else $error("result without finished sum");

endmodule
